// File: src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg: shared definitions for the one-wire bus master
// Phase and request codes, register indexes, reset values and the item and
// register-file types that pass between the front and back parts.
// ----------------------------------------------------------------------------
package owbm_pkg;

    // Fixed widths of the stream fields
    localparam int BYTE_BITS     = 8;
    localparam int BIT_POS_W     = $clog2(BYTE_BITS);
    localparam int REQ_W         = 3;
    localparam int CFG_COUNT     = 8;
    localparam int CFG_INDEX_W   = $clog2(CFG_COUNT);
    localparam int CFG_WIDTH     = 10;
    localparam int PHASE_W       = 3;
    localparam int TIMER_WIDTH_DEF = 10;

    // Request queue between front and back
    localparam int QUEUE_DEPTH   = 4;
    localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W   = QUEUE_PTR_W + 1;

    // Stream packing widths
    localparam int S_TDATA_W     = 16;
    localparam int S_TUSER_W     = 4;
    localparam int M_TDATA_W     = 16;

    // Sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
    localparam logic [PHASE_W-1:0] PH_RST_LOW   = 3'd1;
    localparam logic [PHASE_W-1:0] PH_RST_WAIT  = 3'd2;
    localparam logic [PHASE_W-1:0] PH_RST_REC   = 3'd3;
    localparam logic [PHASE_W-1:0] PH_SLOT_LOW  = 3'd4;
    localparam logic [PHASE_W-1:0] PH_SLOT_WAIT = 3'd5;
    localparam logic [PHASE_W-1:0] PH_SLOT_REC  = 3'd6;

    // Request kinds
    localparam logic [REQ_W-1:0] OP_RESET = 3'd0;
    localparam logic [REQ_W-1:0] OP_WBYTE = 3'd1;
    localparam logic [REQ_W-1:0] OP_RBYTE = 3'd2;
    localparam logic [REQ_W-1:0] OP_WBIT  = 3'd3;
    localparam logic [REQ_W-1:0] OP_RBIT  = 3'd4;

    // Register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESET_RECOVER = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ONE_LOW = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_WRITE_ZERO_LOW = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_SLOT_RECOVER  = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_LOW      = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] CFG_READ_SAMPLE   = 3'd7;

    typedef logic [CFG_COUNT-1:0][CFG_WIDTH-1:0] cfg_array_t;

    // Register values after reset, highest index first
    localparam cfg_array_t CFG_RESET_VALUES = {
        10'd12, 10'd10, 10'd60, 10'd90, 10'd10, 10'd500, 10'd40, 10'd500
    };

    // One classified tick as it travels through the queue
    typedef struct packed {
        logic                  start;
        logic [REQ_W-1:0]      req_type;
        logic [BYTE_BITS-1:0]  write_data;
        logic                  line_level;
    } tick_item_t;

    // One result as it waits in the output register
    typedef struct packed {
        logic                  drive_low;
        logic                  busy_res;
        logic                  done_res;
        logic                  presence;
        logic [BYTE_BITS-1:0]  read_data;
    } tick_result_t;

    function automatic logic is_read_op(input logic [REQ_W-1:0] op);
        return (op == OP_RBYTE) || (op == OP_RBIT);
    endfunction

endpackage

// File: src/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master: one-wire bus master sequenced by tick requests
// Front part queues ticks, back part runs the reset and bit-slot timing.
// ----------------------------------------------------------------------------
// Usage:
//   Each request on the s_ channel is one bus tick: the sampled line level and
//   optionally a command (reset/presence, write byte, read byte, write bit,
//   read bit). Every request yields exactly one result on the m_ channel with
//   the line drive, busy, presence and last read value; tlast marks the tick
//   on which a command finishes. Commands offered while busy are dropped.
//   Slot timings are tick counts written on the cfg_ channel; the user must
//   write them only while idle, the block does not enforce it. Throughput is
//   one tick per cycle while the receiver does not stall; one step per tick.
//   A four-entry queue parts intake from the sequencer and an output register
//   holds the result; when the receiver stalls the queue fills and s_tready
//   falls once it is full. Reset returns the sequencer to idle, clears
//   presence and read data and loads the default timings; no clearing pass.
// ----------------------------------------------------------------------------
module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // write_data[7:0], line_level[8], zeros
    input  logic [S_TUSER_W-1:0]   s_tuser,   // cmd_valid[0], req_type[3:1]
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // drive_low[0], busy_res[1],
                                              // presence[2], read_data[10:3], zeros
    output logic                   m_tlast,   // done_res
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data
);

    logic         q_valid;
    logic         q_ready;
    tick_item_t   q_item;
    tick_result_t res;

    // Intake and queue
    owbm_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_item   (q_item)
    );

    // Slot sequencer
    owbm_back #(
        .TIMER_WIDTH (TIMER_WIDTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_item    (q_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result
    assign m_tdata = {
        (M_TDATA_W - BYTE_BITS - 3)'(0),
        res.read_data,
        res.presence,
        res.busy_res,
        res.drive_low
    };
    assign m_tlast = res.done_res;

endmodule

// File: src/owbm_front.sv
// ----------------------------------------------------------------------------
// owbm_front: tick intake and request queue
// Unpacks each incoming tick, flags a valid command and holds the ticks in a
// short queue so that intake and sequencer stall independently.
// ----------------------------------------------------------------------------
module owbm_front
    import owbm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,
    input  logic [S_TUSER_W-1:0] s_tuser,
    output logic                 q_valid,
    input  logic                 q_ready,
    output tick_item_t           q_item
);

    tick_item_t                 entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]     count_reg, count_next;
    tick_item_t                 in_item;
    logic                       push;
    logic                       pop;

    // Classify the incoming tick: only known request kinds may start work
    always_comb
    begin
        in_item.req_type   = s_tuser[REQ_W:1];
        in_item.start      = s_tuser[0] && (s_tuser[REQ_W:1] <= OP_RBIT);
        in_item.write_data = s_tdata[BYTE_BITS-1:0];
        in_item.line_level = s_tdata[BYTE_BITS];
    end

    assign s_tready = (count_reg != QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid  = (count_reg != '0);
    assign q_item   = entry_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the tick payload
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

// File: src/owbm_back.sv
// ----------------------------------------------------------------------------
// owbm_back: slot sequencer, timing registers and result register
// Steps the reset and read/write slot phases by one tick per queued item and
// places each tick's result in an output register.
// ----------------------------------------------------------------------------
module owbm_back
    import owbm_pkg::*;
#(
    parameter int TIMER_WIDTH = TIMER_WIDTH_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    output logic                   q_ready,
    input  tick_item_t             q_item,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_WIDTH-1:0]   cfg_data,
    output logic                   res_valid,
    input  logic                   res_ready,
    output tick_result_t           res
);

    cfg_array_t               cfg_reg;
    logic [PHASE_W-1:0]       phase_reg, phase_next;
    logic [TIMER_WIDTH-1:0]   tick_reg, tick_next;
    logic [BIT_POS_W-1:0]     bitpos_reg, bitpos_next;
    logic [REQ_W-1:0]         op_reg, op_next;
    logic [BYTE_BITS-1:0]     shift_reg, shift_next;
    logic                     pres_reg, pres_next;
    logic [BYTE_BITS-1:0]     last_read_reg, last_read_next;
    logic                     out_valid_reg;
    tick_result_t             out_reg, out_next;
    logic                     take;
    logic [CFG_WIDTH-1:0]     lim_sel;
    logic [TIMER_WIDTH-1:0]   lim;
    logic [TIMER_WIDTH-1:0]   tick_inc;

    assign cfg_ready = 1'b1;
    assign q_ready   = !out_valid_reg || res_ready;
    assign take      = q_valid && q_ready;
    assign res_valid = out_valid_reg;
    assign res       = out_reg;

    // Timing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= CFG_RESET_VALUES;
        end
        else if (cfg_valid)
        begin
            cfg_reg[cfg_index] <= cfg_data;
        end
    end

    // Step the sequencer by one tick
    always_comb
    begin
        phase_next     = phase_reg;
        tick_next      = tick_reg;
        bitpos_next    = bitpos_reg;
        op_next        = op_reg;
        shift_next     = shift_reg;
        pres_next      = pres_reg;
        last_read_next = last_read_reg;
        out_next       = '0;
        lim_sel        = cfg_reg[CFG_SLOT_RECOVER];
        lim            = '0;
        tick_inc       = '0;

        // Start a command only from idle
        if (phase_reg == PH_IDLE && q_item.start)
        begin
            op_next     = q_item.req_type;
            bitpos_next = '0;
            tick_next   = '0;
            shift_next  = is_read_op(q_item.req_type) ? '0 : q_item.write_data;
            phase_next  = (q_item.req_type == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
        end

        // Pick the length of the current phase
        unique case (phase_next)
            PH_RST_LOW:   lim_sel = cfg_reg[CFG_RESET_LOW];
            PH_RST_WAIT:  lim_sel = cfg_reg[CFG_PRESENCE_WAIT];
            PH_RST_REC:   lim_sel = cfg_reg[CFG_RESET_RECOVER];
            PH_SLOT_LOW:
            begin
                if (is_read_op(op_next))
                begin
                    lim_sel = cfg_reg[CFG_READ_LOW];
                end
                else if (shift_next[bitpos_next])
                begin
                    lim_sel = cfg_reg[CFG_WRITE_ONE_LOW];
                end
                else
                begin
                    lim_sel = cfg_reg[CFG_WRITE_ZERO_LOW];
                end
            end
            PH_SLOT_WAIT: lim_sel = cfg_reg[CFG_READ_SAMPLE];
            default:      lim_sel = cfg_reg[CFG_SLOT_RECOVER];
        endcase
        lim = TIMER_WIDTH'(lim_sel);
        if (lim == '0)
        begin
            lim = TIMER_WIDTH'(1);
        end

        if (phase_next != PH_IDLE)
        begin
            out_next.busy_res  = 1'b1;
            out_next.drive_low = (phase_next == PH_RST_LOW) || (phase_next == PH_SLOT_LOW);
            tick_inc           = tick_next + 1'b1;
            tick_next          = tick_inc;
            if (tick_inc >= lim)
            begin
                tick_next = '0;
                unique case (phase_next)
                    PH_RST_LOW:
                    begin
                        phase_next = PH_RST_WAIT;
                    end
                    PH_RST_WAIT:
                    begin
                        pres_next  = !q_item.line_level;
                        phase_next = PH_RST_REC;
                    end
                    PH_RST_REC:
                    begin
                        phase_next        = PH_IDLE;
                        out_next.done_res = 1'b1;
                    end
                    PH_SLOT_LOW:
                    begin
                        phase_next = is_read_op(op_next) ? PH_SLOT_WAIT : PH_SLOT_REC;
                    end
                    PH_SLOT_WAIT:
                    begin
                        if (q_item.line_level)
                        begin
                            shift_next[bitpos_next] = 1'b1;
                        end
                        phase_next = PH_SLOT_REC;
                    end
                    PH_SLOT_REC:
                    begin
                        if ((op_next == OP_WBYTE || op_next == OP_RBYTE) &&
                            bitpos_next != BIT_POS_W'(BYTE_BITS - 1))
                        begin
                            bitpos_next = bitpos_next + 1'b1;
                            phase_next  = PH_SLOT_LOW;
                        end
                        else
                        begin
                            if (is_read_op(op_next))
                            begin
                                last_read_next = shift_next;
                            end
                            phase_next        = PH_IDLE;
                            out_next.done_res = 1'b1;
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                    end
                endcase
            end
        end

        out_next.presence  = pres_next;
        out_next.read_data = last_read_next;
    end

    // Hold sequencer state; advance only when a tick is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            tick_reg      <= '0;
            bitpos_reg    <= '0;
            op_reg        <= OP_RESET;
            shift_reg     <= '0;
            pres_reg      <= 1'b0;
            last_read_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (take)
            begin
                phase_reg     <= phase_next;
                tick_reg      <= tick_next;
                bitpos_reg    <= bitpos_next;
                op_reg        <= op_next;
                shift_reg     <= shift_next;
                pres_reg      <= pres_next;
                last_read_reg <= last_read_next;
                out_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            out_reg <= out_next;
        end
    end

    // Idle sequencer has a cleared phase timer
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_IDLE) |-> (tick_reg == '0))
        else $error("tick timer not cleared while idle");

    // Bit position moves only for byte requests
    assert property (@(posedge clk) disable iff (!rst_n)
        (bitpos_reg != '0) |-> (op_reg == OP_WBYTE || op_reg == OP_RBYTE))
        else $error("bit position moved on a non-byte request");

    // A tick taken while idle without a command reports not busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && phase_reg == PH_IDLE && !q_item.start) |=> !out_reg.busy_res)
        else $error("busy reported without a command");

    // Line drive and completion only while a command runs
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.drive_low || out_reg.done_res)) |-> out_reg.busy_res)
        else $error("drive or done outside a command");

endmodule

// File: sim/tb_one_wire_bus_master.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_one_wire_bus_master: self-checking bench for the one-wire bus master
// Streams bus ticks into the block and checks every tick result against a
// local sequencer model (reset/presence, byte and bit slots, ignored
// commands). Timings are rewritten between phases: reset values, all ones,
// all zeros and small random sets. The sender runs in random bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module tb_one_wire_bus_master;
    import owbm_pkg::*;

    localparam int TW = TIMER_WIDTH_DEF;

    // One bus tick as the bench sees it
    typedef struct {
        logic                 cmd;
        logic [REQ_W-1:0]     req;
        logic [BYTE_BITS-1:0] wdata;
        logic                 line;
    } bus_tick_t;

    logic                   clk;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic [S_TUSER_W-1:0]   s_tuser   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_WIDTH-1:0]   cfg_data  = '0;

    one_wire_bus_master u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Ticks waiting to be sent and results still owed by the block
    bus_tick_t    pending_ticks[$];
    tick_result_t expected_results[$];
    bus_tick_t    cur_tick;
    int unsigned  ticks_queued = 0;
    int unsigned  ticks_taken  = 0;
    int unsigned  error_count  = 0;
    int           burst_left   = 1;
    int           gap_left     = 0;
    int           run_left     = 0;
    int           stall_left   = 0;

    // Sequencer model state
    logic [CFG_WIDTH-1:0] timing [CFG_COUNT];
    logic [PHASE_W-1:0]   seq_phase = PH_IDLE;
    logic [TW-1:0]        tick_cnt  = '0;
    logic [BIT_POS_W-1:0] bit_pos   = '0;
    logic [REQ_W-1:0]     seq_op    = OP_RESET;
    logic [BYTE_BITS-1:0] shreg     = '0;
    logic                 pres_flag = 1'b0;
    logic [BYTE_BITS-1:0] rd_last   = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 100)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    function automatic logic op_reads(input logic [REQ_W-1:0] op);
        return (op == OP_RBYTE) || (op == OP_RBIT);
    endfunction

    // Length of the current phase in ticks; a zero count lasts one tick
    function automatic logic [TW-1:0] phase_len();
        logic [CFG_WIDTH-1:0] lim;
        case (seq_phase)
            PH_RST_LOW:   lim = timing[CFG_RESET_LOW];
            PH_RST_WAIT:  lim = timing[CFG_PRESENCE_WAIT];
            PH_RST_REC:   lim = timing[CFG_RESET_RECOVER];
            PH_SLOT_LOW:
            begin
                if (op_reads(seq_op))
                    lim = timing[CFG_READ_LOW];
                else if (shreg[bit_pos])
                    lim = timing[CFG_WRITE_ONE_LOW];
                else
                    lim = timing[CFG_WRITE_ZERO_LOW];
            end
            PH_SLOT_WAIT: lim = timing[CFG_READ_SAMPLE];
            default:      lim = timing[CFG_SLOT_RECOVER];
        endcase
        return (lim == '0) ? TW'(1) : TW'(lim);
    endfunction

    // Advance the sequencer model by one tick and record the result it owes
    task automatic predict_bus_tick(input bus_tick_t t);
        tick_result_t  r;
        logic [TW-1:0] lim;
        r = '0;
        if (seq_phase == PH_IDLE && t.cmd && t.req <= OP_RBIT)
        begin
            seq_op    = t.req;
            bit_pos   = '0;
            tick_cnt  = '0;
            shreg     = op_reads(t.req) ? '0 : t.wdata;
            seq_phase = (t.req == OP_RESET) ? PH_RST_LOW : PH_SLOT_LOW;
        end
        if (seq_phase != PH_IDLE)
        begin
            lim         = phase_len();
            r.busy_res  = 1'b1;
            r.drive_low = (seq_phase == PH_RST_LOW) || (seq_phase == PH_SLOT_LOW);
            tick_cnt    = tick_cnt + 1'b1;
            if (tick_cnt >= lim)
            begin
                tick_cnt = '0;
                case (seq_phase)
                    PH_RST_LOW:  seq_phase = PH_RST_WAIT;
                    PH_RST_WAIT:
                    begin
                        pres_flag = ~t.line;
                        seq_phase = PH_RST_REC;
                    end
                    PH_RST_REC:
                    begin
                        seq_phase  = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                    PH_SLOT_LOW: seq_phase = op_reads(seq_op) ? PH_SLOT_WAIT : PH_SLOT_REC;
                    PH_SLOT_WAIT:
                    begin
                        if (t.line)
                            shreg[bit_pos] = 1'b1;
                        seq_phase = PH_SLOT_REC;
                    end
                    default:
                    begin
                        if ((seq_op == OP_WBYTE || seq_op == OP_RBYTE) &&
                            bit_pos < BIT_POS_W'(BYTE_BITS - 1))
                        begin
                            bit_pos   = bit_pos + 1'b1;
                            seq_phase = PH_SLOT_LOW;
                        end
                        else
                        begin
                            if (op_reads(seq_op))
                                rd_last = shreg;
                            seq_phase  = PH_IDLE;
                            r.done_res = 1'b1;
                        end
                    end
                endcase
            end
        end
        r.presence  = pres_flag;
        r.read_data = rd_last;
        expected_results.push_back(r);
    endtask

    // Sender: present queued ticks in bursts with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        logic next_valid;
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                predict_bus_tick(cur_tick);
                ticks_taken++;
            end
            if (!s_tvalid || s_tready)
            begin
                next_valid = 1'b0;
                if (gap_left > 0)
                    gap_left--;
                else if (pending_ticks.size() > 0)
                begin
                    cur_tick   = pending_ticks.pop_front();
                    s_tdata    <= {{(S_TDATA_W - BYTE_BITS - 1){1'b0}}, cur_tick.line,
                                   cur_tick.wdata};
                    s_tuser    <= {cur_tick.req, cur_tick.cmd};
                    next_valid = 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
                s_tvalid <= next_valid;
            end
        end
    end

    // Receiver: ready runs and stalls of random length, now and then a long run
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (run_left > 0)
        begin
            run_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            run_left   = ($urandom_range(0, 7) == 0) ? 300 : $urandom_range(0, 30);
            stall_left = $urandom_range(1, 8);
            m_tready <= 1'b0;
        end
    end

    // Check each result against the oldest expectation
    always @(posedge clk)
    begin
        tick_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected");
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[0] !== want.drive_low)
                    report_mismatch($sformatf("drive_low %b, want %b", m_tdata[0],
                                              want.drive_low));
                if (m_tdata[1] !== want.busy_res)
                    report_mismatch($sformatf("busy %b, want %b", m_tdata[1],
                                              want.busy_res));
                if (m_tlast !== want.done_res)
                    report_mismatch($sformatf("done %b, want %b", m_tlast, want.done_res));
                if (m_tdata[2] !== want.presence)
                    report_mismatch($sformatf("presence %b, want %b", m_tdata[2],
                                              want.presence));
                if (m_tdata[10:3] !== want.read_data)
                    report_mismatch($sformatf("read_data %h, want %h", m_tdata[10:3],
                                              want.read_data));
            end
        end
    end

    task automatic queue_tick(input logic cmd, input logic [REQ_W-1:0] req,
                              input logic [BYTE_BITS-1:0] wd, input logic line);
        bus_tick_t t;
        t.cmd   = cmd;
        t.req   = req;
        t.wdata = wd;
        t.line  = line;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    // Tick with no command and random content elsewhere
    task automatic queue_idle(input logic line);
        queue_tick(1'b0, REQ_W'($urandom_range(0, 7)), BYTE_BITS'($urandom), line);
    endtask

    task automatic queue_random(input int n);
        logic [REQ_W-1:0] req;
        repeat (n)
        begin
            req = ($urandom_range(0, 9) == 0) ? REQ_W'($urandom_range(5, 7))
                                              : REQ_W'($urandom_range(0, 4));
            queue_tick($urandom_range(0, 2) == 0, req, BYTE_BITS'($urandom),
                       1'($urandom_range(0, 1)));
        end
    endtask

    // Drain every request, then feed idle ticks until the sequencer is idle
    task automatic settle();
        forever
        begin
            while (ticks_taken != ticks_queued || expected_results.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
            if (seq_phase == PH_IDLE)
                break;
            repeat (16) queue_idle(1'($urandom_range(0, 1)));
        end
    endtask

    task automatic write_timing(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_WIDTH-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        timing[idx] = val;
        cfg_valid <= 1'b0;
    endtask

    task automatic write_all_timings(input logic [CFG_WIDTH-1:0] lo,
                                     input logic [CFG_WIDTH-1:0] hi);
        for (int i = 0; i < CFG_COUNT; i++)
            write_timing(CFG_INDEX_W'(i), CFG_WIDTH'($urandom_range(lo, hi)));
    endtask

    // Stimulus
    initial
    begin
        logic [BYTE_BITS-1:0] rd_pattern;
        for (int i = 0; i < CFG_COUNT; i++)
            timing[i] = CFG_RESET_VALUES[i];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Reset timings: one short slot of each kind
        queue_tick(1'b1, OP_WBIT, 8'h01, 1'b1);
        settle();
        queue_tick(1'b1, OP_RBIT, 8'h00, 1'b1);
        settle();

        // All counts one: every phase is a single tick, so line levels line up
        write_all_timings(1, 1);
        queue_tick(1'b1, OP_RESET, 8'h00, 1'b1);
        queue_idle(1'b0);
        queue_idle(1'b1);
        queue_tick(1'b1, OP_RESET, 8'h00, 1'b0);
        queue_idle(1'b1);
        queue_idle(1'b0);
        queue_tick(1'b1, OP_WBYTE, 8'hff, 1'b1);
        repeat (15) queue_idle(1'b1);
        // a second write byte starts; the reset offered in mid byte below is dropped
        queue_tick(1'b1, OP_WBYTE, 8'h00, 1'b0);
        repeat (4) queue_idle(1'b0);
        queue_tick(1'b1, OP_RESET, 8'h00, 1'b0);
        repeat (10) queue_idle(1'b0);
        rd_pattern = 8'h96;
        for (int b = 0; b < BYTE_BITS; b++)
        begin
            queue_tick(b == 0, OP_RBYTE, 8'h00, 1'b0);
            queue_idle(rd_pattern[b]);
            queue_idle(1'b0);
        end
        queue_tick(1'b1, OP_RBIT, 8'h00, 1'b1);
        queue_idle(1'b1);
        queue_idle(1'b1);
        queue_tick(1'b1, OP_RBIT, 8'hff, 1'b0);
        queue_idle(1'b0);
        queue_idle(1'b0);
        // command on the done tick is dropped
        queue_tick(1'b1, OP_WBIT, 8'hfe, 1'b1);
        queue_tick(1'b1, OP_RBYTE, 8'h00, 1'b1);
        queue_tick(1'b1, OP_WBIT, 8'h01, 1'b1);
        queue_idle(1'b1);
        // unknown request kinds leave the block idle
        queue_tick(1'b1, 3'd5, 8'h55, 1'b1);
        queue_tick(1'b1, 3'd6, 8'haa, 1'b0);
        queue_tick(1'b1, 3'd7, 8'hff, 1'b1);
        queue_tick(1'b1, OP_RESET, 8'h00, 1'b1);
        queue_idle(1'b0);
        queue_idle(1'b0);
        settle();

        // Zero counts behave as one tick
        write_all_timings(0, 0);
        queue_random(50);
        settle();

        write_all_timings(1, 6);
        queue_random(50);
        settle();

        write_all_timings(0, 3);
        queue_random(50);
        settle();

        write_all_timings(1, 8);
        queue_random(50);
        settle();

        repeat (10) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
